@@ design/lds_pkg.sv @@
// lds_pkg: shared constants and the sequencer state type for the
// linear diophantine solver; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lds_pkg;

    // default operand width of the coefficient and right-hand-side words
    localparam int OPERAND_WIDTH_DEF = 21;
    // fixed width of the solution words
    localparam int RESULT_WIDTH = 41;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_MS,
        ST_MT,
        ST_FIN,
        ST_KDIV,
        ST_MX,
        ST_MY,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

@@ design/lds_div.sv @@
// lds_div: iterative signed divider, one quotient bit per cycle,
// truncating quotient and remainder; uses lds_pkg for the default width
`timescale 1ns / 1ps
`default_nettype none

module lds_div #(
    parameter int W = lds_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic signed [W:0]   dividend,
    input  wire logic signed [W:0]   divisor,
    output logic                     done,
    output logic signed [W:0]        quot,
    output logic signed [W:0]        rem
);

    localparam int CNT_W = $clog2(W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [W-1:0]     num_reg, num_next;
    logic [W-1:0]     den_reg, den_next;
    logic [W-1:0]     rem_reg, rem_next;
    logic             neg_q_reg, neg_q_next;
    logic             neg_r_reg, neg_r_next;

    logic [W:0]       mag_n;
    logic [W:0]       mag_d;
    logic [W+1:0]     trial;

    always_comb
    begin
        mag_n = dividend[W] ? (W + 1)'(-dividend) : dividend;
        mag_d = divisor[W] ? (W + 1)'(-divisor) : divisor;
        trial = {1'b0, rem_reg, num_reg[W-1]} - {2'b00, den_reg};

        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;

        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(W);
            num_next   = mag_n[W-1:0];
            den_next   = mag_d[W-1:0];
            rem_next   = '0;
            neg_q_next = dividend[W] ^ divisor[W];
            neg_r_next = dividend[W];
        end
        else if (busy_reg)
        begin
            // restoring step: keep the difference unless it borrowed
            if (trial[W+1])
            begin
                rem_next = {rem_reg[W-2:0], num_reg[W-1]};
                num_next = {num_reg[W-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[W-1:0];
                num_next = {num_reg[W-2:0], 1'b1};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        den_reg   <= den_next;
        rem_reg   <= rem_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    // sign fix-up: quotient takes the xor of signs, remainder the dividend sign
    assign done = done_reg;
    assign quot = neg_q_reg ? (W + 1)'(-{1'b0, num_reg}) : {1'b0, num_reg};
    assign rem  = neg_r_reg ? (W + 1)'(-{1'b0, rem_reg}) : {1'b0, rem_reg};

endmodule

`default_nettype wire

@@ design/lds_mul.sv @@
// lds_mul: shared signed multiplier with a registered product;
// uses lds_pkg for the default widths
`timescale 1ns / 1ps
`default_nettype none

module lds_mul #(
    parameter int A_W = lds_pkg::OPERAND_WIDTH_DEF + 2,
    parameter int B_W = lds_pkg::OPERAND_WIDTH_DEF + 1
) (
    input  wire logic                    clk,
    input  wire logic                    en,
    input  wire logic signed [A_W-1:0]   a,
    input  wire logic signed [B_W-1:0]   b,
    output logic signed [A_W+B_W-1:0]    prod
);

    logic signed [A_W+B_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

@@ design/linear_diophantine_solver_top.sv @@
// linear_diophantine_solver_top: sequencer and coefficient registers of the
// extended euclidean solver; uses lds_pkg, lds_div and lds_mul
// each euclid round runs the check state, a divide in lds_div and the multiply-update
//   states ST_MS and ST_MT
// throughput: one word at a time, in_stall is high from acceptance until the result
//   is handed to the output register, which may still hold the previous result
// reset: rst_n clears the sequencer, divider control and output valid; data registers
//   are not reset
`timescale 1ns / 1ps
`default_nettype none

module linear_diophantine_solver_top #(
    parameter int OPERAND_WIDTH = lds_pkg::OPERAND_WIDTH_DEF
) (
    input  wire logic                                     clk,
    input  wire logic                                     rst_n,
    // input channel
    input  wire logic                                     in_valid,
    output logic                                          in_stall,
    input  wire logic signed [OPERAND_WIDTH-1:0]          coef_a,
    input  wire logic signed [OPERAND_WIDTH-1:0]          coef_b,
    input  wire logic signed [OPERAND_WIDTH-1:0]          rhs_c,
    // output channel
    output logic                                          out_valid,
    input  wire logic                                     out_stall,
    output logic                                          solvable,
    output logic signed [lds_pkg::RESULT_WIDTH-1:0]       sol_x,
    output logic signed [lds_pkg::RESULT_WIDTH-1:0]       sol_y
);

    // remainders and quotients need one bit more than the operands
    // (a most negative value divided by minus one), bezout coefficients two
    localparam int RW  = OPERAND_WIDTH + 1;
    localparam int QW  = OPERAND_WIDTH + 1;
    localparam int CW  = OPERAND_WIDTH + 2;
    localparam int PW  = CW + QW;
    localparam int RES = lds_pkg::RESULT_WIDTH;
    localparam int EW  = (PW > RES) ? PW : RES;

    lds_pkg::state_t state_reg, state_next;

    // euclid working set
    logic signed [RW-1:0] r0_reg, r0_next;
    logic signed [RW-1:0] r1_reg, r1_next;
    logic signed [CW-1:0] s0_reg, s0_next;
    logic signed [CW-1:0] s1_reg, s1_next;
    logic signed [CW-1:0] t0_reg, t0_next;
    logic signed [CW-1:0] t1_reg, t1_next;
    logic signed [RW-1:0] c_reg, c_next;
    logic signed [QW-1:0] q_reg, q_next;
    logic signed [RW-1:0] nr_reg, nr_next;
    logic signed [QW-1:0] k_reg, k_next;

    // finished result, waiting for the output register
    logic                 res_sol_reg, res_sol_next;
    logic [RES-1:0]       res_x_reg, res_x_next;
    logic [RES-1:0]       res_y_reg, res_y_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic                 solvable_reg, solvable_next;
    logic [RES-1:0]       sol_x_reg, sol_x_next;
    logic [RES-1:0]       sol_y_reg, sol_y_next;

    // shared unit hookup
    logic                 div_start;
    logic signed [RW-1:0] div_dividend;
    logic signed [RW-1:0] div_divisor;
    logic                 div_done;
    logic signed [RW-1:0] div_quot;
    logic signed [RW-1:0] div_rem;

    logic                 mul_en;
    logic signed [CW-1:0] mul_a;
    logic signed [QW-1:0] mul_b;
    logic signed [PW-1:0] mul_prod;
    logic signed [EW-1:0] mul_ext;

    lds_div #(
        .W (OPERAND_WIDTH)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    lds_mul #(
        .A_W (CW),
        .B_W (QW)
    ) u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (mul_prod)
    );

    // product sign-extended (or kept) before wrapping to the result width
    assign mul_ext = EW'(mul_prod);

    always_comb
    begin
        state_next     = state_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        c_next         = c_reg;
        q_next         = q_reg;
        nr_next        = nr_reg;
        k_next         = k_reg;
        res_sol_next   = res_sol_reg;
        res_x_next     = res_x_reg;
        res_y_next     = res_y_reg;
        solvable_next  = solvable_reg;
        sol_x_next     = sol_x_reg;
        sol_y_next     = sol_y_reg;

        // output word leaves when the far side takes it
        out_valid_next = out_valid_reg && out_stall;

        div_start      = 1'b0;
        div_dividend   = r0_reg;
        div_divisor    = r1_reg;
        mul_en         = 1'b0;
        mul_a          = s1_reg;
        mul_b          = q_reg;

        case (state_reg)
            lds_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    r0_next    = RW'(coef_a);
                    r1_next    = RW'(coef_b);
                    c_next     = RW'(rhs_c);
                    s0_next    = CW'(1);
                    s1_next    = '0;
                    t0_next    = '0;
                    t1_next    = CW'(1);
                    state_next = lds_pkg::ST_CHECK;
                end
            end

            lds_pkg::ST_CHECK:
            begin
                // loop ends once the remainder reaches zero
                if (r1_reg == '0)
                begin
                    state_next = lds_pkg::ST_FIN;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = lds_pkg::ST_DIV;
                end
            end

            lds_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    q_next     = div_quot;
                    nr_next    = div_rem;
                    // s1 * q goes into the multiplier straight away
                    mul_en     = 1'b1;
                    mul_a      = s1_reg;
                    mul_b      = div_quot;
                    state_next = lds_pkg::ST_MS;
                end
            end

            lds_pkg::ST_MS:
            begin
                s0_next    = s1_reg;
                s1_next    = s0_reg - mul_prod[CW-1:0];
                mul_en     = 1'b1;
                mul_a      = t1_reg;
                mul_b      = q_reg;
                state_next = lds_pkg::ST_MT;
            end

            lds_pkg::ST_MT:
            begin
                t0_next    = t1_reg;
                t1_next    = t0_reg - mul_prod[CW-1:0];
                r0_next    = r1_reg;
                r1_next    = nr_reg;
                state_next = lds_pkg::ST_CHECK;
            end

            lds_pkg::ST_FIN:
            begin
                // both coefficients zero leave a zero gcd: no solution
                if (r0_reg == '0)
                begin
                    res_sol_next = 1'b0;
                    res_x_next   = '0;
                    res_y_next   = '0;
                    state_next   = lds_pkg::ST_DONE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = c_reg;
                    div_divisor  = r0_reg;
                    state_next   = lds_pkg::ST_KDIV;
                end
            end

            lds_pkg::ST_KDIV:
            begin
                if (div_done)
                begin
                    if (div_rem != '0)
                    begin
                        res_sol_next = 1'b0;
                        res_x_next   = '0;
                        res_y_next   = '0;
                        state_next   = lds_pkg::ST_DONE;
                    end
                    else
                    begin
                        k_next     = div_quot;
                        mul_en     = 1'b1;
                        mul_a      = s0_reg;
                        mul_b      = div_quot;
                        state_next = lds_pkg::ST_MX;
                    end
                end
            end

            lds_pkg::ST_MX:
            begin
                res_x_next = mul_ext[RES-1:0];
                mul_en     = 1'b1;
                mul_a      = t0_reg;
                mul_b      = k_reg;
                state_next = lds_pkg::ST_MY;
            end

            lds_pkg::ST_MY:
            begin
                res_y_next   = mul_ext[RES-1:0];
                res_sol_next = 1'b1;
                state_next   = lds_pkg::ST_DONE;
            end

            lds_pkg::ST_DONE:
            begin
                // hand over once the output register is free or draining
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    solvable_next  = res_sol_reg;
                    sol_x_next     = res_x_reg;
                    sol_y_next     = res_y_reg;
                    state_next     = lds_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = lds_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lds_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        s0_reg      <= s0_next;
        s1_reg      <= s1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        c_reg       <= c_next;
        q_reg       <= q_next;
        nr_reg      <= nr_next;
        k_reg       <= k_next;
        res_sol_reg <= res_sol_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        solvable_reg <= solvable_next;
        sol_x_reg   <= sol_x_next;
        sol_y_reg   <= sol_y_next;
    end

    // input side is open only between words
    assign in_stall  = (state_reg != lds_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign solvable  = solvable_reg;
    assign sol_x     = sol_x_reg;
    assign sol_y     = sol_y_reg;

    // an accepted word closes the input side on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input side still open after a word was taken");

    // divider only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == lds_pkg::ST_DIV || state_reg == lds_pkg::ST_KDIV))
        else $error("divider finished outside a divide wait state");

    // an unsolvable result carries zero solutions
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !solvable) |-> (sol_x == '0 && sol_y == '0))
        else $error("unsolvable result with nonzero solution");

endmodule

`default_nettype wire
